/* rtl/blt_pkg.sv */
// Shared constants, types and arithmetic helpers for the bouncing-line trail generator.
package blt_pkg;

	localparam int MAX_TRAIL_LINES_DEF = 64;
	localparam int COORD_SHIFT_DEF     = 6;

	localparam int CW   = 16;  // scaled coordinate width
	localparam int VW   = 10;  // velocity width
	localparam int PW   = 10;  // pixel coordinate width
	localparam int IW   = 8;   // intensity width
	localparam int TLW  = 7;   // trail_lines register width
	localparam int CFGW = 16;  // config data width
	localparam int CIW  = 3;   // config index width

	localparam logic [CIW-1:0] REG_MAX_X     = 3'd0;
	localparam logic [CIW-1:0] REG_MAX_Y     = 3'd1;
	localparam logic [CIW-1:0] REG_TRAIL     = 3'd2;
	localparam logic [CIW-1:0] REG_MAX_INT   = 3'd3;
	localparam logic [CIW-1:0] REG_INT_STEP  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;     // write one head endpoint
		logic rd_head;  // read head entry for a tick
		logic adv;      // move head endpoints, write new head
		logic issue;    // read one trail line for output
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic s1_valid;
		logic out_free;
		logic last;     // current line index is the newest
	} sts_t;

	typedef struct packed {
		logic [CW-1:0]        coord;
		logic signed [VW-1:0] vel;
	} adv_t;

	function automatic logic signed [VW-1:0] neg_vel(logic signed [VW-1:0] d);
		logic signed [VW-1:0] r;
		if (d[VW-1] && d[VW-2:0] == '0)
			r = {1'b0, {(VW-1){1'b1}}};
		else
			r = -d;
		return r;
	endfunction

	// one axis step with bounce, half step after the bounce, clamp into [0, lim]
	function automatic adv_t advance(logic [CW-1:0] p, logic signed [VW-1:0] d,
			logic [CW-1:0] lim);
		logic signed [CW+1:0] q;
		logic signed [CW+1:0] m;
		logic signed [CW+1:0] half;
		logic signed [VW-1:0] nd;
		logic under;
		logic over;
		adv_t r;
		q = $signed({2'b00, p}) + $signed({{(CW+2-VW){d[VW-1]}}, d});
		m = $signed({2'b00, lim});
		under = q < 0;
		over = q > m;
		nd = d;
		if (under || over) begin
			nd = neg_vel(d);
			half = $signed({{(CW+2-VW){nd[VW-1]}}, nd});
			half = (half + $signed({{(CW+1){1'b0}}, nd[VW-1]})) >>> 1;
			q = under ? half : m + half;
		end
		if (q < 0)
			q = '0;
		if (q > m)
			q = m;
		r.coord = q[CW-1:0];
		r.vel = nd;
		return r;
	endfunction

endpackage

/* rtl/bouncing_line_trail_generator_unit.sv */
// Top level of the bouncing-line trail generator.
// Usage:
//   Input channel (in_valid/in_ready): one request per item. kind=1 loads the
//   position and velocity of one head endpoint and cuts the trail to one line;
//   it gives no result. kind=0 ticks one frame.
//   A tick moves the head endpoints, then emits every second stored line,
//   oldest first, on the output channel (out_valid/out_ready); frame_last
//   marks the newest line, which comes last.
//   After the head update, each line of a tick is read from the single read
//   port of the trail memory, one line per cycle, into a stage register and
//   then the output register while the receiver takes them. A tick holds the
//   input until its last line has left the stage register.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), used
//   while the block is idle.
//   Reset clears the head position and velocities, sets the line count to one
//   and restores register defaults; trail memory is undefined until loaded.
//   A stalled receiver holds the output register; reads stop after one more
//   line is buffered, and the next request waits until the tick is drained.
module bouncing_line_trail_generator_unit #(
	parameter int MAX_TRAIL_LINES = blt_pkg::MAX_TRAIL_LINES_DEF,
	parameter int COORD_SHIFT     = blt_pkg::COORD_SHIFT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [blt_pkg::CIW-1:0]      cfg_index,
	input  logic [blt_pkg::CFGW-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic                         point_sel,
	input  logic [blt_pkg::CW-1:0]       load_x,
	input  logic [blt_pkg::CW-1:0]       load_y,
	input  logic signed [blt_pkg::VW-1:0] load_dx,
	input  logic signed [blt_pkg::VW-1:0] load_dy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [blt_pkg::PW-1:0]       start_x,
	output logic [blt_pkg::PW-1:0]       start_y,
	output logic [blt_pkg::PW-1:0]       end_x,
	output logic [blt_pkg::PW-1:0]       end_y,
	output logic [blt_pkg::IW-1:0]       intensity,
	output logic                         frame_last
);
	import blt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	blt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	blt_dp #(
		.MAX_TRAIL_LINES (MAX_TRAIL_LINES),
		.COORD_SHIFT     (COORD_SHIFT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.point_sel  (point_sel),
		.load_x     (load_x),
		.load_y     (load_y),
		.load_dx    (load_dx),
		.load_dy    (load_dy),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.intensity  (intensity),
		.frame_last (frame_last)
	);

endmodule

/* rtl/blt_ctrl.sv */
// Sequencer for load, head update and line emission.
module blt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  blt_pkg::sts_t sts,
	output blt_pkg::cmd_t cmd
);
	import blt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ADV   = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept && kind;
				cmd.rd_head = accept && !kind;
				if (accept && !kind)
					state_nx = ST_ADV;
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.issue = !sts.s1_valid || sts.out_free;
				if (cmd.issue && sts.last)
					state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.s1_valid)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

endmodule

/* rtl/blt_dp.sv */
// Datapath: config registers, trail memory, head motion and output pipeline.
module blt_dp #(
	parameter int MAX_TRAIL_LINES = blt_pkg::MAX_TRAIL_LINES_DEF,
	parameter int COORD_SHIFT     = blt_pkg::COORD_SHIFT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [blt_pkg::CIW-1:0]   cfg_index,
	input  logic [blt_pkg::CFGW-1:0]  cfg_data,
	input  logic                      point_sel,
	input  logic [blt_pkg::CW-1:0]    load_x,
	input  logic [blt_pkg::CW-1:0]    load_y,
	input  logic signed [blt_pkg::VW-1:0] load_dx,
	input  logic signed [blt_pkg::VW-1:0] load_dy,
	input  blt_pkg::cmd_t             cmd,
	output blt_pkg::sts_t             sts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [blt_pkg::PW-1:0]    start_x,
	output logic [blt_pkg::PW-1:0]    start_y,
	output logic [blt_pkg::PW-1:0]    end_x,
	output logic [blt_pkg::PW-1:0]    end_y,
	output logic [blt_pkg::IW-1:0]    intensity,
	output logic                      frame_last
);
	import blt_pkg::*;

	localparam int DEPTH = 2 * MAX_TRAIL_LINES;
	localparam int AW    = $clog2(DEPTH);
	localparam int LCW   = $clog2(DEPTH + 1);
	localparam int KW    = (MAX_TRAIL_LINES > 1) ? $clog2(MAX_TRAIL_LINES) : 1;
	localparam logic [AW:0]    DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0]  LAST_A  = AW'(DEPTH - 1);
	localparam logic [TLW-1:0] MAX_TL  = TLW'(MAX_TRAIL_LINES);

	function automatic logic [PW-1:0] pix(logic [CW-1:0] c);
		logic [CW+PW-1:0] w;
		w = {{PW{1'b0}}, c} >> COORD_SHIFT;
		return w[PW-1:0];
	endfunction

	// config
	logic [CW-1:0]  max_x_q;
	logic [CW-1:0]  max_y_q;
	logic [TLW-1:0] trail_q;
	logic [IW-1:0]  max_int_q;
	logic [IW-1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= 16'd1023;
			max_y_q <= 16'd1023;
			trail_q <= 7'd5;
			max_int_q <= 8'd255;
			step_q <= 8'd51;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_X:    max_x_q <= cfg_data;
				REG_MAX_Y:    max_y_q <= cfg_data;
				REG_TRAIL:    trail_q <= cfg_data[TLW-1:0];
				REG_MAX_INT:  max_int_q <= cfg_data[IW-1:0];
				REG_INT_STEP: step_q <= cfg_data[IW-1:0];
				default: ;
			endcase
		end
	end

	// control state
	logic [AW-1:0]        head_q;
	logic [LCW-1:0]       lc_q;
	logic [AW-1:0]        i_q;
	logic signed [VW-1:0] vel_q [4];

	// trail memory, one array per endpoint, {x, y}
	logic [2*CW-1:0] mem0 [DEPTH];
	logic [2*CW-1:0] mem1 [DEPTH];
	logic [2*CW-1:0] rd0_s1;
	logic [2*CW-1:0] rd1_s1;
	logic            valid_s1;
	logic            last_s1;
	logic [KW-1:0]   k_s1;

	logic [TLW-1:0] eff;
	logic [LCW-1:0] cap;
	logic [LCW-1:0] lc_c;
	logic [AW-1:0]  nh;
	logic [AW-1:0]  i_start;
	logic [AW:0]    sum;
	logic [AW-1:0]  emit_addr;
	logic [AW-1:0]  raddr;
	logic           ren;
	logic           we0;
	logic           we1;
	logic [AW-1:0]  waddr;
	logic [2*CW-1:0] wd0;
	logic [2*CW-1:0] wd1;
	logic           out_free;
	adv_t           ax0;
	adv_t           ay0;
	adv_t           ax1;
	adv_t           ay1;

	always_comb begin
		if (trail_q == '0)
			eff = TLW'(1);
		else if (trail_q > MAX_TL)
			eff = MAX_TL;
		else
			eff = trail_q;
		cap = LCW'({eff, 1'b0});
		lc_c = (lc_q > cap) ? cap : lc_q;
		if (lc_c > LCW'(1))
			nh = (head_q == '0) ? LAST_A : head_q - AW'(1);
		else
			nh = head_q;
		i_start = AW'(lc_c - LCW'(1));
		i_start[0] = 1'b0;
		sum = {1'b0, head_q} + {1'b0, i_q};
		if (sum >= DEPTH_W)
			sum = sum - DEPTH_W;
		emit_addr = sum[AW-1:0];
	end

	assign ax0 = advance(rd0_s1[2*CW-1:CW], vel_q[0], max_x_q);
	assign ay0 = advance(rd0_s1[CW-1:0],    vel_q[1], max_y_q);
	assign ax1 = advance(rd1_s1[2*CW-1:CW], vel_q[2], max_x_q);
	assign ay1 = advance(rd1_s1[CW-1:0],    vel_q[3], max_y_q);

	assign we0 = (cmd.load && !point_sel) || cmd.adv;
	assign we1 = (cmd.load && point_sel) || cmd.adv;
	assign waddr = cmd.adv ? nh : head_q;
	assign wd0 = cmd.adv ? {ax0.coord, ay0.coord} : {load_x, load_y};
	assign wd1 = cmd.adv ? {ax1.coord, ay1.coord} : {load_x, load_y};
	assign raddr = cmd.rd_head ? head_q : emit_addr;
	assign ren = cmd.rd_head || cmd.issue;

	always_ff @(posedge clk) begin
		if (we0)
			mem0[waddr] <= wd0;
		if (we1)
			mem1[waddr] <= wd1;
		if (ren) begin
			rd0_s1 <= mem0[raddr];
			rd1_s1 <= mem1[raddr];
		end
		if (cmd.issue) begin
			last_s1 <= (i_q >> 1) == '0;
			k_s1 <= KW'(i_q >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			lc_q <= LCW'(1);
			i_q <= '0;
			for (int n = 0; n < 4; n++)
				vel_q[n] <= '0;
		end else if (cmd.load) begin
			lc_q <= LCW'(1);
			if (point_sel) begin
				vel_q[2] <= load_dx;
				vel_q[3] <= load_dy;
			end else begin
				vel_q[0] <= load_dx;
				vel_q[1] <= load_dy;
			end
		end else if (cmd.adv) begin
			head_q <= nh;
			i_q <= i_start;
			lc_q <= (lc_c < cap) ? lc_c + LCW'(1) : lc_c;
			vel_q[0] <= ax0.vel;
			vel_q[1] <= ay0.vel;
			vel_q[2] <= ax1.vel;
			vel_q[3] <= ay1.vel;
		end else if (cmd.issue && i_q > AW'(1)) begin
			i_q <= i_q - AW'(2);
		end
	end

	// output stage
	logic [KW+IW-1:0] drop;
	logic [IW-1:0]    int_c;
	logic             out_valid_q;

	assign out_free = !out_valid_q || out_ready;
	assign drop = (KW+IW)'(k_s1) * (KW+IW)'(step_q);
	assign int_c = (drop >= (KW+IW)'(max_int_q)) ? '0 : max_int_q - drop[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue)
				valid_s1 <= 1'b1;
			else if (out_free)
				valid_s1 <= 1'b0;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			start_x <= pix(rd0_s1[2*CW-1:CW]);
			start_y <= pix(rd0_s1[CW-1:0]);
			end_x <= pix(rd1_s1[2*CW-1:CW]);
			end_y <= pix(rd1_s1[CW-1:0]);
			intensity <= int_c;
			frame_last <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign sts.s1_valid = valid_s1;
	assign sts.out_free = out_free;
	assign sts.last = (i_q >> 1) == '0;

endmodule

/* bench/tb_bouncing_line_trail_generator_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for the bouncing-line trail generator: random and directed frames vs a predictor.

localparam logic KIND_TICK = 1'b0;
localparam logic KIND_LOAD = 1'b1;
localparam logic [blt_pkg::CIW-1:0] REG_NONE = 3'd7;
localparam int TRAIL_DEPTH = 2 * blt_pkg::MAX_TRAIL_LINES_DEF;

typedef struct {
	logic                         kind;
	logic                         point_sel;
	logic [blt_pkg::CW-1:0]       load_x;
	logic [blt_pkg::CW-1:0]       load_y;
	logic signed [blt_pkg::VW-1:0] load_dx;
	logic signed [blt_pkg::VW-1:0] load_dy;
} trail_request_t;

typedef struct {
	logic [blt_pkg::PW-1:0] start_x;
	logic [blt_pkg::PW-1:0] start_y;
	logic [blt_pkg::PW-1:0] end_x;
	logic [blt_pkg::PW-1:0] end_y;
	logic [blt_pkg::IW-1:0] intensity;
	logic                   frame_last;
} drawn_line_t;

class line_scoreboard;
	int seg_x[TRAIL_DEPTH][2];
	int seg_y[TRAIL_DEPTH][2];
	int vel[4];
	int head;
	int lines;
	int lim_x, lim_y, trail, peak, step;
	drawn_line_t expected[$];
	int errors, lines_checked, ticks, loads;

	function new();
		vel = '{default: 0};
		head = 0;
		lines = 1;
		lim_x = 1023;
		lim_y = 1023;
		trail = 5;
		peak = 255;
		step = 51;
		errors = 0;
		lines_checked = 0;
		ticks = 0;
		loads = 0;
	endfunction

	function void write_reg(logic [blt_pkg::CIW-1:0] idx, logic [blt_pkg::CFGW-1:0] v);
		case (idx)
			blt_pkg::REG_MAX_X: lim_x = int'(v);
			blt_pkg::REG_MAX_Y: lim_y = int'(v);
			blt_pkg::REG_TRAIL: trail = int'(v[blt_pkg::TLW-1:0]);
			blt_pkg::REG_MAX_INT: peak = int'(v[blt_pkg::IW-1:0]);
			blt_pkg::REG_INT_STEP: step = int'(v[blt_pkg::IW-1:0]);
			default: ;
		endcase
	endfunction

	function int flip_velocity(int d);
		return (d <= -512) ? 511 : -d;
	endfunction

	function int bounce_step(input int p, inout int d, input int lim);
		int q;
		q = p + d;
		if (q < 0) begin
			d = flip_velocity(d);
			q = d / 2;
		end else if (q > lim) begin
			d = flip_velocity(d);
			q = lim + d / 2;
		end
		if (q < 0)
			q = 0;
		if (q > lim)
			q = lim;
		return q;
	endfunction

	function logic [blt_pkg::PW-1:0] pixel(int c);
		return blt_pkg::PW'((c >> blt_pkg::COORD_SHIFT_DEF) & 'h3FF);
	endfunction

	function void note_request(trail_request_t r);
		int cap, t, s, at, drop;
		drawn_line_t ln;
		if (r.kind == KIND_LOAD) begin
			s = r.point_sel;
			seg_x[head][s] = r.load_x;
			seg_y[head][s] = r.load_y;
			vel[2 * s] = r.load_dx;
			vel[2 * s + 1] = r.load_dy;
			lines = 1;
			loads++;
			return;
		end
		t = trail;
		if (t < 1)
			t = 1;
		if (t > blt_pkg::MAX_TRAIL_LINES_DEF)
			t = blt_pkg::MAX_TRAIL_LINES_DEF;
		cap = 2 * t;
		if (lines > cap)
			lines = cap;
		if (lines > 1) begin
			at = (head + TRAIL_DEPTH - 1) % TRAIL_DEPTH;
			seg_x[at] = seg_x[head];
			seg_y[at] = seg_y[head];
			head = at;
		end
		for (int e = 0; e < 2; e++) begin
			seg_x[head][e] = bounce_step(seg_x[head][e], vel[2 * e], lim_x);
			seg_y[head][e] = bounce_step(seg_y[head][e], vel[2 * e + 1], lim_y);
		end
		// every second line, oldest first
		for (int i = (lines - 1) & ~1; i >= 0; i -= 2) begin
			at = (head + i) % TRAIL_DEPTH;
			drop = (i / 2) * step;
			ln.start_x = pixel(seg_x[at][0]);
			ln.start_y = pixel(seg_y[at][0]);
			ln.end_x = pixel(seg_x[at][1]);
			ln.end_y = pixel(seg_y[at][1]);
			ln.intensity = (drop >= peak) ? '0 : blt_pkg::IW'(peak - drop);
			ln.frame_last = (i == 0);
			expected.push_back(ln);
		end
		if (lines < cap)
			lines++;
		ticks++;
	endfunction

	function int pending();
		return expected.size();
	endfunction

	task report(string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	task check_line(drawn_line_t got);
		drawn_line_t want;
		string bad;
		if (expected.size() == 0) begin
			report($sformatf("unexpected line %0d,%0d-%0d,%0d i%0d", got.start_x, got.start_y,
				got.end_x, got.end_y, got.intensity));
			return;
		end
		want = expected.pop_front();
		bad = "";
		if (got.start_x !== want.start_x)
			bad = {bad, " start_x"};
		if (got.start_y !== want.start_y)
			bad = {bad, " start_y"};
		if (got.end_x !== want.end_x)
			bad = {bad, " end_x"};
		if (got.end_y !== want.end_y)
			bad = {bad, " end_y"};
		if (got.intensity !== want.intensity)
			bad = {bad, " intensity"};
		if (got.frame_last !== want.frame_last)
			bad = {bad, " frame_last"};
		if (bad != "")
			report($sformatf("line %0d:%s got %0d,%0d-%0d,%0d i%0d l%0d want %0d,%0d-%0d,%0d i%0d l%0d",
				lines_checked, bad, got.start_x, got.start_y, got.end_x, got.end_y, got.intensity,
				got.frame_last, want.start_x, want.start_y, want.end_x, want.end_y,
				want.intensity, want.frame_last));
		lines_checked++;
	endtask
endclass

module tb_bouncing_line_trail_generator_unit;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 10;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [blt_pkg::CIW-1:0]       cfg_index = '0;
	logic [blt_pkg::CFGW-1:0]      cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          kind = KIND_TICK;
	logic                          point_sel = 1'b0;
	logic [blt_pkg::CW-1:0]        load_x = '0;
	logic [blt_pkg::CW-1:0]        load_y = '0;
	logic signed [blt_pkg::VW-1:0] load_dx = '0;
	logic signed [blt_pkg::VW-1:0] load_dy = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [blt_pkg::PW-1:0]        start_x;
	logic [blt_pkg::PW-1:0]        start_y;
	logic [blt_pkg::PW-1:0]        end_x;
	logic [blt_pkg::PW-1:0]        end_y;
	logic [blt_pkg::IW-1:0]        intensity;
	logic                          frame_last;

	line_scoreboard sb;
	bit idle_on = 1'b1;
	bit long_hold = 1'b0;
	int quiet = 0;

	bouncing_line_trail_generator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .point_sel(point_sel), .load_x(load_x), .load_y(load_y),
		.load_dx(load_dx), .load_dy(load_dy),
		.out_valid(out_valid), .out_ready(out_ready),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.intensity(intensity), .frame_last(frame_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("stalled for %0d cycles", quiet);
				$display("simulation failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		drawn_line_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{start_x, start_y, end_x, end_y, intensity, frame_last};
			sb.check_line(got);
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic trail_request_t load_req(logic sel, logic [15:0] x, logic [15:0] y,
			logic [9:0] dx, logic [9:0] dy);
		trail_request_t r;
		r = '{KIND_LOAD, sel, x, y, dx, dy};
		return r;
	endfunction

	function automatic trail_request_t tick_req();
		trail_request_t r;
		r = '{KIND_TICK, 1'($urandom), 16'($urandom), 16'($urandom), 10'($urandom),
			10'($urandom)};
		return r;
	endfunction

	function automatic trail_request_t make_request(int load_odds);
		trail_request_t r;
		r = tick_req();
		if ($urandom_range(0, load_odds - 1) == 0) begin
			r.kind = KIND_LOAD;
			if ($urandom_range(0, 3) != 0) begin
				r.load_x = 16'($urandom_range(0, sb.lim_x));
				r.load_y = 16'($urandom_range(0, sb.lim_y));
			end
		end
		return r;
	endfunction

	task automatic send_request(trail_request_t r);
		in_valid <= 1'b1;
		kind <= r.kind;
		point_sel <= r.point_sel;
		load_x <= r.load_x;
		load_y <= r.load_y;
		load_dx <= r.load_dx;
		load_dy <= r.load_dy;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [blt_pkg::CIW-1:0] idx, int v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= blt_pkg::CFGW'(v);
		sb.write_reg(idx, blt_pkg::CFGW'(v));
		@(posedge clk);
	endtask

	task automatic apply_settings(int mx, int my, int tl, int mi, int st);
		wait_idle();
		cfg_write(REG_NONE, $urandom);
		cfg_write(blt_pkg::REG_MAX_X, mx);
		cfg_write(blt_pkg::REG_MAX_Y, my);
		cfg_write(blt_pkg::REG_TRAIL, tl);
		cfg_write(blt_pkg::REG_MAX_INT, mi);
		cfg_write(blt_pkg::REG_INT_STEP, st);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int count, int load_odds);
		repeat (count) begin
			sender_gap();
			send_request(make_request(load_odds));
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both endpoints loaded before the first tick; bounces at both walls
		send_request(load_req(1'b0, 16'd0, 16'd1023, 10'h200, 10'h1FF));
		send_request(load_req(1'b1, 16'hFFFF, 16'hFFFF, 10'h1FF, 10'h200));
		repeat (12) send_request(tick_req());
		send_request(load_req(1'b0, 16'd500, 16'd20, 10'h001, 10'h3FF));
		repeat (2) send_request(tick_req());
		send_request(load_req(1'b1, 16'd1023, 16'd0, 10'h000, 10'h000));
		repeat (3) send_request(tick_req());

		apply_settings(65535, 65535, 64, 255, 4);
		long_hold = 1'b1;
		run_phase(50, 30);
		apply_settings(1, 1, 1, 1, 0);
		run_phase(25, 8);
		apply_settings(0, 0, 0, 0, 255);
		run_phase(25, 8);
		apply_settings(4095, 2047, 127, 200, 255);
		run_phase(130, 1000);
		// shrinks a long trail
		apply_settings(16000, 9000, 3, 255, 100);
		run_phase(30, 10);
		apply_settings(8191, 8191, 10, 255, 25);
		idle_on = 1'b0;
		run_phase(30, 12);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("ran %0d ticks and %0d loads over seven register settings, %0d lines checked",
			sb.ticks, sb.loads, sb.lines_checked);
		$display("%0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

/* filelist.f */
rtl/blt_pkg.sv
rtl/blt_ctrl.sv
rtl/blt_dp.sv
rtl/bouncing_line_trail_generator_unit.sv
bench/tb_bouncing_line_trail_generator_unit.sv
